/* design/assert_macros.svh */
// Assertion macros for the top-level design file.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/qlat_pkg.sv */
// Package for the Q-learning action table unit: sizes, codes and shared types.
// Depends on nothing.
package qlat_pkg;

    localparam int NUM_STATES  = 16;
    localparam int MAX_ACTIONS = 8;
    localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int MW = $clog2(MAX_ACTIONS);
    localparam int AW = SW + MW;
    localparam int QDEPTH = NUM_STATES * MAX_ACTIONS;

    localparam logic [3:0]  RST_ACTION_COUNT = 4'd8;
    localparam logic [15:0] RST_GREEDY       = 16'd6554;
    localparam logic [15:0] RST_LRATE        = 16'd6554;
    localparam logic [15:0] RST_DISCOUNT     = 16'd58982;

    localparam logic [1:0] CFG_ACTION_COUNT = 2'd0;
    localparam logic [1:0] CFG_GREEDY       = 2'd1;
    localparam logic [1:0] CFG_LRATE        = 2'd2;
    localparam logic [1:0] CFG_DISCOUNT     = 2'd3;

    // The last code is not an operation; such transactions are ignored.
    typedef enum logic [1:0] {
        ACT_CHOOSE = 2'd0,
        ACT_QLEARN = 2'd1,
        ACT_SARSA  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_act;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CHK, OP_PICK, OP_DIV_INIT, OP_DIV_STEP,
        OP_RD_QC, OP_RD_QSM, OP_CAP_Q, OP_BN, OP_RD_QN, OP_RD_QO,
        OP_CAP_QOLD, OP_MUL1, OP_TGT, OP_MUL2, OP_NEW, OP_WR, OP_RD_QPB,
        OP_CMP, OP_SCAN_RD, OP_SCAN_CMP, OP_SCAN_END, OP_FIN, OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic s_bad;
        logic is_choose;
        logic upd_bad;
        logic m_ok;
        logic greedy;
        logic div_last;
        logic gain;
        logic is_pb;
        logic scan_last;
        logic out_busy;
    } t_dp_status;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_DECIDE, ST_PICK, ST_DIV0, ST_DIV, ST_RQ, ST_RQM,
        ST_CAPQ, ST_BN, ST_RQN, ST_RQO, ST_CAPO, ST_MUL1, ST_TGT, ST_MUL2,
        ST_NEW, ST_WR, ST_RPB, ST_CMP, ST_SRD, ST_SCMP, ST_SEND, ST_FIN,
        ST_DONE
    } t_state;

endpackage

/* design/qlat_ctrl.sv */
// Controller state machine of the Q-learning action table unit.
// Depends on qlat_pkg; drives the datapath through one operation code per cycle.
module qlat_ctrl import qlat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_op     o_op
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_CHK;
            ST_CHK:    n_state = ST_DECIDE;
            ST_DECIDE: begin
                priority if (i_status.s_bad) n_state = ST_DONE;
                else if (i_status.is_choose) n_state = i_status.greedy ? ST_PICK : ST_DIV0;
                else if (i_status.upd_bad) n_state = i_status.m_ok ? ST_RQM : ST_DONE;
                else n_state = ST_BN;
            end
            ST_PICK:   n_state = ST_RQ;
            ST_DIV0:   n_state = ST_DIV;
            ST_DIV:    if (i_status.div_last) n_state = ST_RQ;
            ST_RQ:     n_state = ST_CAPQ;
            ST_RQM:    n_state = ST_CAPQ;
            ST_CAPQ:   n_state = ST_DONE;
            ST_BN:     n_state = ST_RQN;
            ST_RQN:    n_state = ST_RQO;
            ST_RQO:    n_state = ST_CAPO;
            ST_CAPO:   n_state = ST_MUL1;
            ST_MUL1:   n_state = ST_TGT;
            ST_TGT:    n_state = ST_MUL2;
            ST_MUL2:   n_state = ST_NEW;
            ST_NEW:    n_state = ST_WR;
            ST_WR:     n_state = ST_RPB;
            ST_RPB:    n_state = ST_CMP;
            ST_CMP: begin
                if (i_status.gain || !i_status.is_pb) n_state = ST_FIN;
                else n_state = ST_SRD;
            end
            ST_SRD:    n_state = ST_SCMP;
            ST_SCMP:   n_state = i_status.scan_last ? ST_SEND : ST_SRD;
            ST_SEND:   n_state = ST_FIN;
            ST_FIN:    n_state = ST_DONE;
            ST_DONE:   if (!i_status.out_busy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE);
        o_op    = OP_NONE;
        unique case (r_state)
            ST_IDLE:   if (i_valid) o_op = OP_LOAD;
            ST_CHK:    o_op = OP_CHK;
            ST_PICK:   o_op = OP_PICK;
            ST_DIV0:   o_op = OP_DIV_INIT;
            ST_DIV:    o_op = OP_DIV_STEP;
            ST_RQ:     o_op = OP_RD_QC;
            ST_RQM:    o_op = OP_RD_QSM;
            ST_CAPQ:   o_op = OP_CAP_Q;
            ST_BN:     o_op = OP_BN;
            ST_RQN:    o_op = OP_RD_QN;
            ST_RQO:    o_op = OP_RD_QO;
            ST_CAPO:   o_op = OP_CAP_QOLD;
            ST_MUL1:   o_op = OP_MUL1;
            ST_TGT:    o_op = OP_TGT;
            ST_MUL2:   o_op = OP_MUL2;
            ST_NEW:    o_op = OP_NEW;
            ST_WR:     o_op = OP_WR;
            ST_RPB:    o_op = OP_RD_QPB;
            ST_CMP:    o_op = OP_CMP;
            ST_SRD:    o_op = OP_SCAN_RD;
            ST_SCMP:   o_op = OP_SCAN_CMP;
            ST_SEND:   o_op = OP_SCAN_END;
            ST_FIN:    o_op = OP_FIN;
            ST_DONE:   if (!i_status.out_busy) o_op = OP_OUT;
            default:   o_op = OP_NONE;
        endcase
    end

endmodule

/* design/qlat_dp.sv */
// Datapath of the Q-learning action table unit: registers, Q memory, best-move
// table, divider steps and update arithmetic. Depends on qlat_pkg.
module qlat_dp import qlat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_op             i_op,
    output t_dp_status         o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_action,
    input  logic [3:0]         i_state_index,
    input  logic [2:0]         i_move_index,
    input  logic [3:0]         i_next_state,
    input  logic [2:0]         i_next_move,
    input  logic signed [31:0] i_reward,
    input  logic [15:0]        i_random_fraction,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [2:0]         o_chosen_move,
    output logic [2:0]         o_best_move,
    output logic signed [31:0] o_q_value,
    output logic               o_bad_index
);

    localparam int PW = 53;
    localparam int DW = 36;

    // Configuration registers.
    logic [3:0]  r_cnt;
    logic [15:0] r_eps, r_lr, r_disc;

    // Latched item.
    logic [1:0]         r_act;
    logic [3:0]         r_s, r_ns;
    logic [2:0]         r_m, r_nm;
    logic signed [31:0] r_reward;
    logic [15:0]        r_rand;

    // Working registers.
    logic [3:0]           r_c;
    logic                 r_sok, r_updbad, r_mok, r_greedy;
    logic [2:0]           r_pb, r_nmove, r_chosen, r_best, r_bi, r_k;
    logic signed [31:0]   r_q, r_qn, r_qold, r_new, r_bv;
    logic                 r_bad;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_diff;
    logic [19:0]          r_rem;
    logic [16:0]          r_div;

    // Storage.
    logic signed [31:0] q_mem [QDEPTH];
    logic [QDEPTH-1:0]  r_qvld;
    logic signed [31:0] r_rd;
    logic               r_rdv;
    logic [2:0]         r_bm [NUM_STATES];

    // Output register.
    logic               r_oval, r_obad;
    logic [2:0]         r_ochosen, r_obest;
    logic signed [31:0] r_oq;

    logic [3:0]           c;
    logic                 sok, nsok, mok, nmok, updbad;
    logic [AW-1:0]        raddr, waddr;
    logic [SW-1:0]        bidx;
    logic [2:0]           bm_rd;
    logic signed [31:0]   qout;
    logic signed [PW-1:0] rnd_full, sum;
    logic signed [31:0]   sat;
    logic [19:0]          dshift;

    always_comb begin
        priority if (r_cnt == 4'd0) c = 4'd1;
        else if (32'(r_cnt) > MAX_ACTIONS) c = 4'(MAX_ACTIONS);
        else c = r_cnt;
    end

    assign sok    = 32'(r_s) < NUM_STATES;
    assign nsok   = 32'(r_ns) < NUM_STATES;
    assign mok    = {1'b0, r_m} < c;
    assign nmok   = {1'b0, r_nm} < c;
    assign updbad = (r_act != ACT_QLEARN && r_act != ACT_SARSA) || !nsok || !mok
                    || (r_act == ACT_SARSA && !nmok);

    assign bidx  = (i_op == OP_BN) ? r_ns[SW-1:0] : r_s[SW-1:0];
    assign bm_rd = r_bm[bidx];
    assign qout  = r_rdv ? r_rd : 32'sd0;
    assign waddr = {r_s[SW-1:0], r_m[MW-1:0]};

    always_comb begin
        unique case (i_op)
            OP_RD_QC:   raddr = {r_s[SW-1:0], r_chosen[MW-1:0]};
            OP_RD_QN:   raddr = {r_ns[SW-1:0], r_nmove[MW-1:0]};
            OP_RD_QPB:  raddr = {r_s[SW-1:0], r_pb[MW-1:0]};
            OP_SCAN_RD: raddr = {r_s[SW-1:0], r_k[MW-1:0]};
            default:    raddr = {r_s[SW-1:0], r_m[MW-1:0]};
        endcase
    end

    // Round to nearest with ties upward, then saturate the blended value.
    assign rnd_full = (r_prod + PW'(32768)) >>> 16;
    assign sum      = PW'(r_qold) + rnd_full;
    always_comb begin
        priority if (sum > PW'(32'sh7fff_ffff)) sat = 32'sh7fff_ffff;
        else if (sum < PW'($signed(32'h8000_0000))) sat = $signed(32'h8000_0000);
        else sat = sum[31:0];
    end

    assign dshift = 20'(r_div) << r_k[1:0];

    always_comb begin
        o_status.s_bad     = !r_sok;
        o_status.is_choose = (r_act == ACT_CHOOSE);
        o_status.upd_bad   = r_updbad;
        o_status.m_ok      = r_mok;
        o_status.greedy    = r_greedy;
        o_status.div_last  = (r_k[1:0] == 2'd0);
        o_status.gain      = (r_new > qout);
        o_status.is_pb     = (r_m == r_pb);
        o_status.scan_last = ({1'b0, r_k} == (r_c - 4'd1));
        o_status.out_busy  = r_oval && i_stall;
    end

    // Q memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_WR) begin
            q_mem[waddr] <= r_new;
        end
        r_rd <= q_mem[raddr];
    end

    // Control state: configuration, valid bits, best-move table, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= RST_ACTION_COUNT;
            r_eps  <= RST_GREEDY;
            r_lr   <= RST_LRATE;
            r_disc <= RST_DISCOUNT;
            r_qvld <= '0;
            r_rdv  <= 1'b0;
            r_oval <= 1'b0;
            for (int i = 0; i < NUM_STATES; i++) begin
                r_bm[i] <= 3'd0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTION_COUNT: r_cnt  <= i_cfg_data[3:0];
                    CFG_GREEDY:       r_eps  <= i_cfg_data;
                    CFG_LRATE:        r_lr   <= i_cfg_data;
                    CFG_DISCOUNT:     r_disc <= i_cfg_data;
                    default:          r_cnt  <= r_cnt;
                endcase
            end
            r_rdv <= r_qvld[raddr];
            if (i_op == OP_WR) begin
                r_qvld[waddr] <= 1'b1;
            end
            if (i_op == OP_FIN) begin
                r_bm[r_s[SW-1:0]] <= r_pb;
            end
            if (i_op == OP_OUT) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_act    <= i_action;
                r_s      <= i_state_index;
                r_m      <= i_move_index;
                r_ns     <= i_next_state;
                r_nm     <= i_next_move;
                r_reward <= i_reward;
                r_rand   <= i_random_fraction;
            end
            OP_CHK: begin
                r_c      <= c;
                r_sok    <= sok;
                r_updbad <= updbad;
                r_mok    <= mok;
                r_greedy <= (r_rand <= r_eps);
                r_pb     <= sok ? bm_rd : 3'd0;
                r_best   <= sok ? bm_rd : 3'd0;
                r_chosen <= 3'd0;
                r_q      <= 32'sd0;
                r_bad    <= !sok || ((r_act != ACT_CHOOSE) && updbad);
            end
            OP_PICK: r_chosen <= r_pb;
            OP_DIV_INIT: begin
                r_rem    <= 20'(r_rand - r_eps) * 20'(r_c);
                r_div    <= 17'h1_0000 - 17'(r_eps);
                r_k      <= 3'd2;
                r_chosen <= 3'd0;
            end
            OP_DIV_STEP: begin
                if (r_rem >= dshift) begin
                    r_rem <= r_rem - dshift;
                    r_chosen[r_k[1:0]] <= 1'b1;
                end
                r_k <= r_k - 3'd1;
            end
            OP_CAP_Q:    r_q <= qout;
            OP_BN:       r_nmove <= (r_act == ACT_QLEARN) ? bm_rd : r_nm;
            OP_RD_QO:    r_qn <= qout;
            OP_CAP_QOLD: r_qold <= qout;
            OP_MUL1:     r_prod <= PW'($signed({1'b0, r_disc})) * PW'(r_qn);
            OP_TGT:      r_diff <= DW'(PW'(r_reward) + rnd_full - PW'(r_qold));
            OP_MUL2:     r_prod <= PW'($signed({1'b0, r_lr})) * PW'(r_diff);
            OP_NEW:      r_new <= sat;
            OP_CMP: begin
                if (r_new > qout) begin
                    r_pb <= r_m;
                end
                r_k  <= 3'd0;
                r_bi <= 3'd0;
            end
            OP_SCAN_CMP: begin
                if (r_k == 3'd0 || qout > r_bv) begin
                    r_bv <= qout;
                    r_bi <= r_k;
                end
                r_k <= r_k + 3'd1;
            end
            OP_SCAN_END: r_pb <= r_bi;
            OP_FIN: begin
                r_best <= r_pb;
                r_q    <= r_new;
            end
            OP_OUT: begin
                r_ochosen <= r_chosen;
                r_obest   <= r_best;
                r_oq      <= r_q;
                r_obad    <= r_bad;
            end
            default: r_k <= r_k;
        endcase
    end

    assign o_valid       = r_oval;
    assign o_chosen_move = r_ochosen;
    assign o_best_move   = r_obest;
    assign o_q_value     = r_oq;
    assign o_bad_index   = r_obad;

endmodule

/* design/q_learning_action_table_unit.sv */
// Q-learning action table unit, top level. One transaction in gives one out.
// The unit works on one item at a time and stalls its input until the result
// is loaded into the output register; the Q memory has one write port and one
// registered read port, and the multiplier product register is shared. Reset
// (synchronous, active low) clears the Q table valid bits, so every entry reads
// as zero, clears the best moves and loads the default configuration.
`include "assert_macros.svh"
module q_learning_action_table_unit import qlat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // Input channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [3:0]         i_state_index,
    input  logic [2:0]         i_move_index,
    input  logic [3:0]         i_next_state,
    input  logic [2:0]         i_next_move,
    input  logic signed [31:0] i_reward,
    input  logic [15:0]        i_random_fraction,
    // Output channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_chosen_move,
    output logic [2:0]         o_best_move,
    output logic signed [31:0] o_q_value,
    output logic               o_bad_index
);

    // The controller issues one datapath operation each cycle and follows
    // the status flags; the datapath owns all storage. The output register
    // lets a new transaction start while a finished result still waits.
    t_dp_op     op;
    t_dp_status status;

    qlat_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_op     (op)
    );

    qlat_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_state_index     (i_state_index),
        .i_move_index      (i_move_index),
        .i_next_state      (i_next_state),
        .i_next_move       (i_next_move),
        .i_reward          (i_reward),
        .i_random_fraction (i_random_fraction),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_chosen_move     (o_chosen_move),
        .o_best_move       (o_best_move),
        .o_q_value         (o_q_value),
        .o_bad_index       (o_bad_index)
    );

    // An ignored transaction never reports a chosen move.
    `ASSERT_IMP(a_bad_no_choice, i_clk, i_rst_n, o_valid && o_bad_index, o_chosen_move == 3'd0)
    // After accepting a transaction the unit is busy on the next cycle.
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // The output register is never reloaded while its result is held.
    `ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, op == OP_OUT, !(o_valid && i_stall))

endmodule

/* dv/q_learning_action_table_unit_checker.sv */
// Checker for the Q-learning action table unit: watches both channels and the
// configuration port, predicts each result and compares it. Depends on qlat_pkg.
module q_learning_action_table_unit_checker import qlat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_action,
    input  logic [3:0]         i_state_index,
    input  logic [2:0]         i_move_index,
    input  logic [3:0]         i_next_state,
    input  logic [2:0]         i_next_move,
    input  logic signed [31:0] i_reward,
    input  logic [15:0]        i_random_fraction,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_chosen_move,
    input  logic [2:0]         i_best_move,
    input  logic signed [31:0] i_q_value,
    input  logic               i_bad_index,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [2:0]         chosen;
        logic [2:0]         best;
        logic signed [31:0] q;
        logic               bad;
    } t_result;

    // Expected results in arrival order, kept in a small ring buffer.
    t_result            exp_mem [EXP_DEPTH];
    int                 exp_wr = 0;
    int                 exp_rd = 0;
    int                 exp_cnt = 0;
    logic signed [31:0] q_mem [QDEPTH];
    logic [2:0]         best_mem [NUM_STATES];
    logic [3:0]         count_reg;
    logic [15:0]        eps_reg;
    logic [15:0]        lrate_reg;
    logic [15:0]        disc_reg;
    int                 fails = 0;

    // Nearest rounding of a Q16.16 product, ties upward.
    function automatic longint round_q16(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic t_result learn_step(logic [1:0] act, logic [3:0] s, logic [2:0] m,
                                           logic [3:0] ns, logic [2:0] nm,
                                           logic signed [31:0] rew, logic [15:0] r);
        t_result res;
        int      c;
        int      nmv;
        int      pb;
        int      bi;
        longint  qn;
        longint  qold;
        longint  tgt;
        longint  nv;
        longint  num;
        res = '0;
        c = (count_reg == 0) ? 1 : (count_reg > MAX_ACTIONS) ? MAX_ACTIONS : int'(count_reg);
        if (int'(s) >= NUM_STATES) begin
            res.bad = 1'b1;
        end else if (act == ACT_CHOOSE) begin
            if (r <= eps_reg) begin
                res.chosen = best_mem[s];
            end else begin
                num = (longint'(r) - longint'(eps_reg)) * c;
                res.chosen = 3'((num / (65536 - longint'(eps_reg))) % c);
            end
            res.best = best_mem[s];
            res.q = q_mem[s * MAX_ACTIONS + res.chosen];
        end else begin
            res.bad = (act == ACT_UNUSED) || (int'(ns) >= NUM_STATES) || (int'(m) >= c) ||
                      (act == ACT_SARSA && int'(nm) >= c);
            if (!res.bad) begin
                nmv = (act == ACT_QLEARN) ? int'(best_mem[ns]) : int'(nm);
                qn = longint'(q_mem[ns * MAX_ACTIONS + nmv]);
                qold = longint'(q_mem[s * MAX_ACTIONS + m]);
                tgt = longint'(rew) + round_q16(longint'(disc_reg) * qn);
                nv = qold + round_q16(longint'(lrate_reg) * (tgt - qold));
                if (nv > 64'sd2147483647) nv = 64'sd2147483647;
                if (nv < -64'sd2147483648) nv = -64'sd2147483648;
                pb = best_mem[s];
                q_mem[s * MAX_ACTIONS + m] = 32'(nv);
                if (nv > longint'(q_mem[s * MAX_ACTIONS + pb])) begin
                    best_mem[s] = m;
                end else if (int'(m) == pb) begin
                    // The old best lost ground: rescan, the first maximum wins.
                    bi = 0;
                    for (int k = 1; k < c; k++)
                        if (q_mem[s * MAX_ACTIONS + k] > q_mem[s * MAX_ACTIONS + bi]) bi = k;
                    best_mem[s] = 3'(bi);
                end
            end
            res.best = best_mem[s];
            if (int'(m) < c) res.q = q_mem[s * MAX_ACTIONS + m];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < QDEPTH; i++) q_mem[i] = '0;
            for (int i = 0; i < NUM_STATES; i++) best_mem[i] = '0;
            count_reg = RST_ACTION_COUNT;
            eps_reg   = RST_GREEDY;
            lrate_reg = RST_LRATE;
            disc_reg  = RST_DISCOUNT;
            exp_wr  = 0;
            exp_rd  = 0;
            exp_cnt = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (exp_cnt == 0) begin
                    fails++;
                    if (fails <= 10) $display("ERROR: result transaction with nothing expected");
                end else begin
                    want = exp_mem[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt--;
                    if (want.chosen !== i_chosen_move || want.best !== i_best_move ||
                        want.q !== i_q_value || want.bad !== i_bad_index) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: expected chosen %0d best %0d q %0d bad %0d, got %0d %0d %0d %0d",
                                     want.chosen, want.best, want.q, want.bad,
                                     i_chosen_move, i_best_move, i_q_value, i_bad_index);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTION_COUNT: count_reg = i_cfg_data[3:0];
                    CFG_GREEDY:       eps_reg   = i_cfg_data;
                    CFG_LRATE:        lrate_reg = i_cfg_data;
                    CFG_DISCOUNT:     disc_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                if (exp_cnt == EXP_DEPTH) begin
                    fails++;
                    if (fails <= 10) $display("ERROR: more transactions in flight than expected");
                end else begin
                    exp_mem[exp_wr] = learn_step(i_action, i_state_index, i_move_index,
                                                 i_next_state, i_next_move, i_reward,
                                                 i_random_fraction);
                    exp_wr = (exp_wr + 1) % EXP_DEPTH;
                    exp_cnt++;
                end
            end
        end
        o_pending    = exp_cnt;
        o_fail_count = fails;
    end

endmodule

/* dv/q_learning_action_table_unit_tb.sv */
// Testbench top for the Q-learning action table unit: clock, reset, stimulus
// and verdict. Depends on qlat_pkg, the unit and its checker module.
module q_learning_action_table_unit_tb;
    import qlat_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int NUM_PHASES = 7;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_action;
    logic [3:0]         i_state_index;
    logic [2:0]         i_move_index;
    logic [3:0]         i_next_state;
    logic [2:0]         i_next_move;
    logic signed [31:0] i_reward;
    logic [15:0]        i_random_fraction;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_chosen_move;
    logic [2:0]         o_best_move;
    logic signed [31:0] o_q_value;
    logic               o_bad_index;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Shadow of the configuration, used only to steer the random stimulus.
    logic [3:0]  cur_count = RST_ACTION_COUNT;
    logic [15:0] cur_eps   = RST_GREEDY;

    // Receiver control: a requested long hold-off and the random stall pattern.
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    // When set, neither side idles, so the block sees back-to-back traffic.
    bit no_idle = 1'b0;

    q_learning_action_table_unit i_dut (.*);

    q_learning_action_table_unit_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall),
        .i_action, .i_state_index, .i_move_index, .i_next_state, .i_next_move,
        .i_reward, .i_random_fraction,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_chosen_move(o_chosen_move), .i_best_move(o_best_move),
        .i_q_value(o_q_value), .i_bad_index(o_bad_index),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // The receiver changes its stall at the falling edge. A long hold-off is
    // counted here so that the sender keeps offering while the block backs up.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Waits until every expected result has come, plus the worst-case latency.
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_ACTION_COUNT) cur_count = data[3:0];
        if (idx == CFG_GREEDY) cur_eps = data;
    endtask

    task automatic set_config(logic [3:0] cnt, logic [15:0] eps, logic [15:0] lr,
                              logic [15:0] disc);
        wait_idle();
        write_cfg(CFG_ACTION_COUNT, {12'd0, cnt});
        write_cfg(CFG_GREEDY, eps);
        write_cfg(CFG_LRATE, lr);
        write_cfg(CFG_DISCOUNT, disc);
    endtask

    // Offers one transaction and holds it until accepted; valid stays high
    // unless the following gap lowers it.
    task automatic send_item(logic [1:0] act, logic [3:0] s, logic [2:0] m, logic [3:0] ns,
                             logic [2:0] nm, logic signed [31:0] rew, logic [15:0] r);
        int gap;
        i_action = act;
        i_state_index = s;
        i_move_index = m;
        i_next_state = ns;
        i_next_move = nm;
        i_reward = rew;
        i_random_fraction = r;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Mostly well-formed items on a few busy states, with some out-of-range
    // moves and the unused action code mixed in.
    task automatic send_random();
        int          c;
        int          p;
        logic [1:0]  act;
        logic [3:0]  s;
        logic [3:0]  ns;
        logic [2:0]  m;
        logic [2:0]  nm;
        logic [31:0] rew;
        int          r;
        c = (cur_count == 0) ? 1 : (cur_count > MAX_ACTIONS) ? MAX_ACTIONS : int'(cur_count);
        p = $urandom_range(0, 99);
        act = (p < 38) ? ACT_CHOOSE : (p < 64) ? ACT_QLEARN : (p < 94) ? ACT_SARSA : ACT_UNUSED;
        s  = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        ns = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        m  = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, c - 1)) : 3'($urandom);
        nm = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, c - 1)) : 3'($urandom);
        p = $urandom_range(0, 99);
        if (p < 10) rew = 32'h7fffffff;
        else if (p < 20) rew = 32'h80000000;
        else if (p < 60) rew = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        else rew = $urandom;
        p = $urandom_range(0, 99);
        if (p < 30) begin
            r = int'(cur_eps) + $urandom_range(0, 6) - 3;
            r = (r < 0) ? 0 : (r > 65535) ? 65535 : r;
        end else if (p < 40) begin
            r = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        end else begin
            r = $urandom_range(0, 65535);
        end
        send_item(act, s, m, ns, nm, signed'(rew), 16'(r));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ACTION_COUNT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_action = ACT_CHOOSE;
        i_state_index = '0;
        i_move_index = '0;
        i_next_state = '0;
        i_next_move = '0;
        i_reward = '0;
        i_random_fraction = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, at the reset configuration: greedy and spread choice
        // on a cleared table, updates with extreme rewards, the unused code.
        send_item(ACT_CHOOSE, 4'd0, 3'd0, 4'd0, 3'd0, 32'sd0, 16'd0);
        send_item(ACT_CHOOSE, 4'd15, 3'd7, 4'd15, 3'd7, 32'sd0, 16'hffff);
        send_item(ACT_QLEARN, 4'd0, 3'd3, 4'd1, 3'd0, 32'sh7fffffff, 16'd0);
        send_item(ACT_SARSA, 4'd15, 3'd7, 4'd15, 3'd7, 32'sh80000000, 16'hffff);
        send_item(ACT_QLEARN, 4'd0, 3'd3, 4'd0, 3'd0, 32'sh80000000, 16'd0);
        send_item(ACT_UNUSED, 4'd0, 3'd3, 4'd0, 3'd0, 32'sd5, 16'd0);
        send_item(ACT_CHOOSE, 4'd0, 3'd0, 4'd0, 3'd0, 32'sd0, RST_GREEDY);
        send_item(ACT_CHOOSE, 4'd0, 3'd0, 4'd0, 3'd0, 32'sd0, RST_GREEDY + 16'd1);

        // Fewer moves: out-of-range move and next move are flagged.
        set_config(4'd3, 16'd0, 16'hffff, 16'hffff);
        send_item(ACT_QLEARN, 4'd2, 3'd5, 4'd2, 3'd0, 32'sd100, 16'd0);
        send_item(ACT_SARSA, 4'd2, 3'd1, 4'd2, 3'd7, 32'sd100, 16'd0);
        send_item(ACT_CHOOSE, 4'd2, 3'd5, 4'd2, 3'd0, 32'sd0, 16'd0);
        // Full learning rate and discount drive the value into saturation.
        send_item(ACT_QLEARN, 4'd2, 3'd1, 4'd2, 3'd1, 32'sh7fffffff, 16'd0);
        send_item(ACT_SARSA, 4'd2, 3'd1, 4'd2, 3'd1, 32'sh7fffffff, 16'd0);
        send_item(ACT_SARSA, 4'd2, 3'd2, 4'd2, 3'd2, 32'sh80000000, 16'd0);
        send_item(ACT_SARSA, 4'd2, 3'd2, 4'd2, 3'd2, 32'sh80000000, 16'd0);
        // Old best move loses value, so the row is rescanned.
        send_item(ACT_SARSA, 4'd2, 3'd1, 4'd3, 3'd0, 32'sh80000000, 16'd0);
        send_item(ACT_CHOOSE, 4'd2, 3'd0, 4'd0, 3'd0, 32'sd0, 16'hffff);

        // Single move: choices and an update on state 0 with the count lowered to one.
        set_config(4'd1, 16'hffff, 16'd32768, 16'd0);
        send_item(ACT_CHOOSE, 4'd0, 3'd0, 4'd0, 3'd0, 32'sd0, 16'd1234);
        send_item(ACT_QLEARN, 4'd0, 3'd0, 4'd0, 3'd0, 32'sd65536, 16'd0);
        send_item(ACT_CHOOSE, 4'd0, 3'd0, 4'd0, 3'd0, 32'sd0, 16'hffff);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_config(4'd8, RST_GREEDY, RST_LRATE, RST_DISCOUNT);
                1: set_config(4'd1, 16'd0, 16'hffff, 16'd0);
                2: set_config(4'd15, 16'hffff, 16'd0, 16'hffff);
                3: set_config(4'd0, 16'd32768, 16'd32768, 16'd32768);
                4: set_config(4'd8, 16'd0, 16'hffff, 16'hffff);
                default: set_config(4'($urandom_range(0, 15)), 16'($urandom),
                                    16'($urandom), 16'($urandom));
            endcase
            no_idle = (ph == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 4 && n == 40) hold_req = 1'b1;
                send_random();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
